>>> sv/length_framed_byte_receiver_assert.svh
`ifndef LENGTH_FRAMED_BYTE_RECEIVER_ASSERT_SVH
`define LENGTH_FRAMED_BYTE_RECEIVER_ASSERT_SVH

// same-cycle implication under reset
`define LFBR_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("lfbr assertion failed");

// next-cycle implication under reset
`define LFBR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("lfbr assertion failed");

`endif

>>> sv/lfbr_pkg.sv
package lfbr_pkg;

    localparam int FRAME_BYTES_DEF = 64;
    localparam int TOTAL_W         = 7;
    localparam int FIXED_OVERHEAD  = 7;
    localparam int LEN_LO_POS      = 3;
    localparam int LEN_HI_POS      = 4;

    localparam logic [15:0] GAP_TIMEOUT_RST = 16'd10;
    localparam logic [7:0]  HEAD_RST        = 8'hAA;
    localparam logic [7:0]  END_RST         = 8'h55;

    typedef enum logic [1:0] {
        REG_GAP_TIMEOUT = 2'd0,
        REG_HEAD        = 2'd1,
        REG_END         = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [7:0]  rx_value;
        logic [31:0] arrival_ms;
    } in_item_t;

    typedef struct packed {
        logic [7:0]         frame_value;
        logic [TOTAL_W-1:0] frame_total;
        logic               final_flag;
    } out_item_t;

    typedef struct packed {
        logic [15:0] gap_timeout_ms;
        logic [7:0]  head_value;
        logic [7:0]  end_value;
    } cfg_t;

    // one finished frame waiting to be sent
    typedef struct packed {
        logic               bank;
        logic [TOTAL_W-1:0] total;
    } cmd_t;

    // back part hands a bank back to the front part
    typedef struct packed {
        logic done;
        logic bank;
    } rel_t;

endpackage

>>> sv/lfbr_store.sv
module lfbr_store
    import lfbr_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  logic                                aclk,
    input  logic                                wr_en,
    input  logic [$clog2(FRAME_BYTES):0]        wr_addr,
    input  logic [7:0]                          wr_data,
    input  logic                                rd_en,
    input  logic [$clog2(FRAME_BYTES):0]        rd_addr,
    output logic [7:0]                          rd_data
);

    localparam int AW    = $clog2(FRAME_BYTES);
    localparam int DEPTH = 2 * (2 ** AW);

    logic [7:0] frame_mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            frame_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= frame_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/lfbr_fifo.sv
`include "length_framed_byte_receiver_assert.svh"

module lfbr_fifo
    import lfbr_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic wr_en,
    input  cmd_t wr_cmd,
    input  logic rd_en,
    output logic rd_valid,
    output cmd_t rd_cmd
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       full;

    assign full     = (fill_reg == 2'd2);
    assign rd_valid = (fill_reg != 2'd0);
    assign rd_cmd   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (wr_en) begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (rd_en) begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (wr_en && !rd_en) begin
            fill_next = fill_reg + 2'd1;
        end else if (!wr_en && rd_en) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    `LFBR_ASSERT_IMPLY(a_no_overflow, aclk, aresetn, wr_en && !rd_en, !full)

endmodule

>>> sv/lfbr_front.sv
`include "length_framed_byte_receiver_assert.svh"

module lfbr_front
    import lfbr_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  in_item_t                        s_data,
    input  cfg_t                            cfg,
    output logic                            wr_en,
    output logic [$clog2(FRAME_BYTES):0]    wr_addr,
    output logic [7:0]                      wr_data,
    output logic                            push,
    output cmd_t                            push_cmd,
    input  rel_t                            release_bank
);

    localparam int AW = $clog2(FRAME_BYTES);
    localparam int CW = $clog2(FRAME_BYTES + 1);

    logic          collecting_reg, collecting_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] target_reg, target_next;
    logic [31:0]   prev_ms_reg, prev_ms_next;
    logic [7:0]    len_lo_reg, len_lo_next;
    logic          wr_bank_reg, wr_bank_next;
    logic [1:0]    busy_reg, busy_next;

    logic          accept;
    logic [31:0]   gap;
    logic          timeout;
    logic          cur_coll;
    logic [CW-1:0] cur_cnt;
    logic [CW-1:0] cur_tgt;
    logic [CW-1:0] cnt_inc;
    logic [CW-1:0] tgt_new;
    logic [16:0]   total;
    logic          too_long;

    assign s_ready = !busy_reg[wr_bank_reg];
    assign accept  = s_valid && s_ready;
    assign wr_data = s_data.rx_value;

    always_comb begin
        gap      = s_data.arrival_ms - prev_ms_reg;
        timeout  = gap > {16'd0, cfg.gap_timeout_ms};
        cur_coll = collecting_reg && !timeout;
        cur_cnt  = timeout ? '0 : count_reg;
        cur_tgt  = timeout ? '0 : target_reg;
        cnt_inc  = cur_cnt + CW'(1);
        total    = 17'(FIXED_OVERHEAD) + {1'b0, s_data.rx_value, len_lo_reg};
        tgt_new  = cur_tgt;
        too_long = 1'b0;

        collecting_next = collecting_reg;
        count_next      = count_reg;
        target_next     = target_reg;
        prev_ms_next    = prev_ms_reg;
        len_lo_next     = len_lo_reg;
        wr_bank_next    = wr_bank_reg;
        wr_en           = 1'b0;
        wr_addr         = {wr_bank_reg, cur_cnt[AW-1:0]};
        push            = 1'b0;
        push_cmd.bank   = wr_bank_reg;
        push_cmd.total  = TOTAL_W'(cnt_inc);

        if (accept) begin
            prev_ms_next    = s_data.arrival_ms;
            collecting_next = cur_coll;
            count_next      = cur_cnt;
            target_next     = cur_tgt;
            if (!cur_coll) begin
                if (s_data.rx_value == cfg.head_value) begin
                    collecting_next = 1'b1;
                    count_next      = CW'(1);
                    target_next     = '0;
                    wr_en           = 1'b1;
                    wr_addr         = {wr_bank_reg, {AW{1'b0}}};
                end
            end else if (cur_cnt >= CW'(FRAME_BYTES)) begin
                collecting_next = 1'b0;
                count_next      = '0;
                target_next     = '0;
            end else begin
                wr_en = 1'b1;
                if (cur_cnt == CW'(LEN_LO_POS)) begin
                    len_lo_next = s_data.rx_value;
                end
                if (cur_cnt == CW'(LEN_HI_POS) && cur_tgt == '0) begin
                    if (total > 17'(FRAME_BYTES)) begin
                        too_long = 1'b1;
                    end else begin
                        tgt_new = CW'(total);
                    end
                end
                if (too_long) begin
                    collecting_next = 1'b0;
                    count_next      = '0;
                    target_next     = '0;
                end else if (tgt_new != '0 && cnt_inc == tgt_new) begin
                    if (s_data.rx_value == cfg.end_value) begin
                        push         = 1'b1;
                        wr_bank_next = ~wr_bank_reg;
                    end
                    collecting_next = 1'b0;
                    count_next      = '0;
                    target_next     = '0;
                end else if (tgt_new != '0 && cnt_inc > tgt_new) begin
                    collecting_next = 1'b0;
                    count_next      = '0;
                    target_next     = '0;
                end else begin
                    collecting_next = 1'b1;
                    count_next      = cnt_inc;
                    target_next     = tgt_new;
                end
            end
        end

        busy_next = busy_reg;
        if (release_bank.done) begin
            busy_next[release_bank.bank] = 1'b0;
        end
        if (push) begin
            busy_next[wr_bank_reg] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            collecting_reg <= 1'b0;
            count_reg      <= '0;
            target_reg     <= '0;
            prev_ms_reg    <= '0;
            wr_bank_reg    <= 1'b0;
            busy_reg       <= '0;
        end else begin
            collecting_reg <= collecting_next;
            count_reg      <= count_next;
            target_reg     <= target_next;
            prev_ms_reg    <= prev_ms_next;
            wr_bank_reg    <= wr_bank_next;
            busy_reg       <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        len_lo_reg <= len_lo_next;
    end

    `LFBR_ASSERT_IMPLY(a_push_free_bank, aclk, aresetn, push, !busy_reg[wr_bank_reg])
    `LFBR_ASSERT_NEXT(a_push_flips_bank, aclk, aresetn, push, wr_bank_reg != $past(wr_bank_reg))
    `LFBR_ASSERT_IMPLY(a_idle_clears_counts, aclk, aresetn, !collecting_reg, count_reg == '0 && target_reg == '0)

endmodule

>>> sv/lfbr_back.sv
module lfbr_back
    import lfbr_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cmd_valid,
    input  cmd_t                            cmd,
    output logic                            pop,
    output logic                            rd_en,
    output logic [$clog2(FRAME_BYTES):0]    rd_addr,
    input  logic [7:0]                      rd_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output out_item_t                       m_data,
    output rel_t                            release_bank
);

    localparam int AW = $clog2(FRAME_BYTES);

    typedef enum logic [2:0] {
        BK_IDLE  = 3'b001,
        BK_FETCH = 3'b010,
        BK_SEND  = 3'b100
    } bk_state_t;

    bk_state_t          state_reg, state_next;
    logic               bank_reg, bank_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic               last;

    assign last    = (TOTAL_W'(idx_reg) + TOTAL_W'(1)) == total_reg;
    assign rd_addr = {bank_reg, idx_reg};
    assign m_valid = (state_reg == BK_SEND);

    assign m_data.frame_value = rd_data;
    assign m_data.frame_total = total_reg;
    assign m_data.final_flag  = last;

    always_comb begin
        state_next        = state_reg;
        bank_next         = bank_reg;
        total_next        = total_reg;
        idx_next          = idx_reg;
        pop               = 1'b0;
        rd_en             = 1'b0;
        release_bank.done = 1'b0;
        release_bank.bank = bank_reg;
        case (state_reg)
            BK_IDLE: begin
                if (cmd_valid) begin
                    pop        = 1'b1;
                    bank_next  = cmd.bank;
                    total_next = cmd.total;
                    idx_next   = '0;
                    state_next = BK_FETCH;
                end
            end
            BK_FETCH: begin
                rd_en      = 1'b1;
                state_next = BK_SEND;
            end
            BK_SEND: begin
                if (m_ready) begin
                    if (last) begin
                        release_bank.done = 1'b1;
                        state_next        = BK_IDLE;
                    end else begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = BK_FETCH;
                    end
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        bank_reg  <= bank_next;
        total_reg <= total_next;
        idx_reg   <= idx_next;
    end

endmodule

>>> sv/length_framed_byte_receiver.sv
// Length-framed byte receiver. Each input transaction is one received byte with its
// millisecond timestamp; a gap above gap_timeout_ms drops a partial frame, a frame opens
// on head_value, bytes 3 and 4 give the little-endian payload length, and a frame of
// 7 + length bytes whose last byte equals end_value is sent out one byte per output
// transaction with final_flag on the last. The front part takes one byte per cycle and
// writes it into one of two frame banks; a finished frame is queued and sent by the
// back part, each byte by a RAM read (BK_FETCH) and then an output (BK_SEND) step; the
// next byte is not fetched until the current one is taken. The input stalls only while
// the bank it is about to fill still holds a frame that has not been fully sent.
module length_framed_byte_receiver
    import lfbr_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(FRAME_BYTES);

    logic [15:0] gap_timeout_reg;
    logic [7:0]  head_value_reg;
    logic [7:0]  end_value_reg;
    cfg_t        cfg;
    reg_idx_t    reg_idx;
    logic        cfg_wr;

    logic        wr_en;
    logic [AW:0] wr_addr;
    logic [7:0]  wr_data;
    logic        rd_en;
    logic [AW:0] rd_addr;
    logic [7:0]  rd_data;
    logic        push;
    cmd_t        push_cmd;
    logic        pop;
    logic        cmd_valid;
    cmd_t        cmd;
    rel_t        release_bank;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gap_timeout_reg <= GAP_TIMEOUT_RST;
            head_value_reg  <= HEAD_RST;
            end_value_reg   <= END_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_GAP_TIMEOUT: gap_timeout_reg <= pwdata[15:0];
                REG_HEAD:        head_value_reg  <= pwdata[7:0];
                REG_END:         end_value_reg   <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_GAP_TIMEOUT: prdata = {16'd0, gap_timeout_reg};
            REG_HEAD:        prdata = {24'd0, head_value_reg};
            REG_END:         prdata = {24'd0, end_value_reg};
            default:         prdata = '0;
        endcase
    end

    assign cfg.gap_timeout_ms = gap_timeout_reg;
    assign cfg.head_value     = head_value_reg;
    assign cfg.end_value      = end_value_reg;

    lfbr_front #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .cfg          (cfg),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .push         (push),
        .push_cmd     (push_cmd),
        .release_bank (release_bank)
    );

    lfbr_store #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    lfbr_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (push),
        .wr_cmd   (push_cmd),
        .rd_en    (pop),
        .rd_valid (cmd_valid),
        .rd_cmd   (cmd)
    );

    lfbr_back #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .pop          (pop),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .release_bank (release_bank)
    );

endmodule
